FILE: rtl/priority_task_scheduler_macros.svh
// assertion macros used by the scheduler checker
`ifndef PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_MACROS_SVH

// property checked while out of reset
`define PTS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("priority task scheduler check failed");

// property checked through reset as well
`define PTS_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("priority task scheduler reset check failed");

`endif

FILE: rtl/pts_pkg.sv
package pts_pkg;

    // default table depth
    localparam int TASK_SLOTS_DEF = 8;

    // fixed field widths
    localparam int SLOT_W = 3;
    localparam int PRIO_W = 8;
    localparam int TICK_W = 32;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_CREATE = 2'd0,
        FUNC_DELAY  = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_SCHED  = 2'd3
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NO_CURRENT = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    // input beat
    typedef struct packed {
        func_t              func;
        logic [PRIO_W-1:0]  prio;
        logic [TICK_W-1:0]  delay_amount;
    } in_t;

    // result beat
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               found;
        status_t            status;
        logic [TICK_W-1:0]  tick_now;
    } out_t;

    // shared compare unit result
    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_res_t;

endpackage

FILE: rtl/pts_cmp.sv
module pts_cmp (
    input  logic [pts_pkg::TICK_W-1:0] a,
    input  logic [pts_pkg::TICK_W-1:0] b,
    output pts_pkg::cmp_res_t          res
);

    // unsigned magnitude compare shared by tick and schedule walks
    always_comb begin
        res.gt = (a > b);
        res.eq = (a == b);
    end

endmodule

FILE: rtl/pts_mem.sv
module pts_mem #(
    parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          we_prio,
    input  logic                          we_wake,
    input  logic [$clog2(TASK_SLOTS)-1:0] waddr,
    input  logic [pts_pkg::PRIO_W-1:0]    wprio,
    input  logic [pts_pkg::TICK_W-1:0]    wwake,
    input  logic [$clog2(TASK_SLOTS)-1:0] raddr,
    output logic [pts_pkg::PRIO_W-1:0]    rprio,
    output logic [pts_pkg::TICK_W-1:0]    rwake
);

    logic [pts_pkg::PRIO_W-1:0] prio_mem [TASK_SLOTS];
    logic [pts_pkg::TICK_W-1:0] wake_mem [TASK_SLOTS];
    logic [pts_pkg::PRIO_W-1:0] rprio_reg;
    logic [pts_pkg::TICK_W-1:0] rwake_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we_prio) begin
            prio_mem[waddr] <= wprio;
        end
        if (we_wake) begin
            wake_mem[waddr] <= wwake;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rprio_reg <= prio_mem[raddr];
        rwake_reg <= wake_mem[raddr];
    end

    assign rprio = rprio_reg;
    assign rwake = rwake_reg;

endmodule

FILE: rtl/priority_task_scheduler.sv
// delay, and create on a full table: go from idle straight to the done state, which loads the result
// tick and schedule: walk every slot before the done state; create into slot k: the walk stops at slot k
// s_ready comes back together with the result, so a new beat is taken only once the last result is loaded
// the walk reads one slot a cycle; a result that is not taken holds the block in its done state
// synchronous active-low reset empties the table, clears tick count, current slot
// and output valid; priority and wake memories are not cleared
module priority_task_scheduler #(
    parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pts_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pts_pkg::out_t m_data
);

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam int PAD_W = pts_pkg::TICK_W - pts_pkg::PRIO_W;

    pts_pkg::state_t state_reg, state_next;
    pts_pkg::func_t  func_reg, func_next;
    logic [pts_pkg::PRIO_W-1:0] prio_reg, prio_next;
    logic [pts_pkg::PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic                       have_reg, have_next;
    logic [IDX_W-1:0]           best_reg, best_next;
    logic [IDX_W-1:0]           walk_reg, walk_next;
    logic [TASK_SLOTS-1:0]      used_reg, used_next;
    logic [TASK_SLOTS-1:0]      delayed_reg, delayed_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           cur_reg, cur_next;
    logic [pts_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [IDX_W-1:0]           res_slot_reg, res_slot_next;
    logic                       res_found_reg, res_found_next;
    pts_pkg::status_t           res_status_reg, res_status_next;
    logic                       m_valid_reg, m_valid_next;
    pts_pkg::out_t              m_data_reg, m_data_next;

    // memory port
    logic                       we_prio, we_wake;
    logic [IDX_W-1:0]           waddr;
    logic [pts_pkg::TICK_W-1:0] wwake;
    logic [pts_pkg::PRIO_W-1:0] rprio;
    logic [pts_pkg::TICK_W-1:0] rwake;

    // compare unit port
    logic [pts_pkg::TICK_W-1:0] cmp_a, cmp_b;
    pts_pkg::cmp_res_t          cmp_res;

    logic [IDX_W+pts_pkg::SLOT_W-1:0] slot_wide;
    logic                             last_slot;
    logic                             take_beat;

    pts_mem #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_mem (
        .aclk    (aclk),
        .we_prio (we_prio),
        .we_wake (we_wake),
        .waddr   (waddr),
        .wprio   (prio_reg),
        .wwake   (wwake),
        .raddr   (walk_next),
        .rprio   (rprio),
        .rwake   (rwake)
    );

    pts_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    // compare operands: wake check on tick, priority race on schedule
    always_comb begin
        if (func_reg == pts_pkg::FUNC_TICK) begin
            cmp_a = tick_reg;
            cmp_b = rwake;
        end else begin
            cmp_a = {{PAD_W{1'b0}}, rprio};
            cmp_b = {{PAD_W{1'b0}}, best_prio_reg};
        end
    end

    assign take_beat = s_valid && s_ready;
    assign last_slot = (walk_reg == IDX_W'(TASK_SLOTS - 1));
    assign slot_wide = {{pts_pkg::SLOT_W{1'b0}}, res_slot_reg};

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pts_pkg::S_IDLE;
            used_reg    <= '0;
            delayed_reg <= '0;
            count_reg   <= '0;
            cur_reg     <= '0;
            tick_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            delayed_reg <= delayed_next;
            count_reg   <= count_next;
            cur_reg     <= cur_next;
            tick_reg    <= tick_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        prio_reg       <= prio_next;
        best_prio_reg  <= best_prio_next;
        have_reg       <= have_next;
        best_reg       <= best_next;
        walk_reg       <= walk_next;
        res_slot_reg   <= res_slot_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        prio_next       = prio_reg;
        best_prio_next  = best_prio_reg;
        have_next       = have_reg;
        best_next       = best_reg;
        walk_next       = walk_reg;
        used_next       = used_reg;
        delayed_next    = delayed_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        tick_next       = tick_reg;
        res_slot_next   = res_slot_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        we_prio         = 1'b0;
        we_wake         = 1'b0;
        waddr           = walk_reg;
        wwake           = tick_reg + s_data.delay_amount;

        // result beat taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            pts_pkg::S_IDLE: begin
                if (take_beat) begin
                    func_next       = s_data.func;
                    prio_next       = s_data.prio;
                    best_prio_next  = '0;
                    have_next       = 1'b0;
                    best_next       = '0;
                    walk_next       = '0;
                    res_slot_next   = '0;
                    res_found_next  = 1'b0;
                    res_status_next = pts_pkg::ST_OK;
                    unique case (s_data.func)
                        pts_pkg::FUNC_CREATE: begin
                            if (count_reg >= CNT_W'(TASK_SLOTS)) begin
                                res_status_next = pts_pkg::ST_FULL;
                                state_next      = pts_pkg::S_DONE;
                            end else begin
                                state_next = pts_pkg::S_WALK;
                            end
                        end
                        pts_pkg::FUNC_DELAY: begin
                            // sleep the current task if it exists
                            if (used_reg[cur_reg]) begin
                                we_wake               = 1'b1;
                                waddr                 = cur_reg;
                                delayed_next[cur_reg] = 1'b1;
                            end else begin
                                res_status_next = pts_pkg::ST_NO_CURRENT;
                            end
                            state_next = pts_pkg::S_DONE;
                        end
                        pts_pkg::FUNC_TICK: begin
                            tick_next  = tick_reg + 1'b1;
                            state_next = pts_pkg::S_WALK;
                        end
                        pts_pkg::FUNC_SCHED: begin
                            state_next = pts_pkg::S_WALK;
                        end
                        default: begin
                            state_next = pts_pkg::S_DONE;
                        end
                    endcase
                end
            end

            pts_pkg::S_WALK: begin
                walk_next = walk_reg + 1'b1;
                if (last_slot) begin
                    walk_next  = '0;
                    state_next = pts_pkg::S_DONE;
                end
                unique case (func_reg)
                    pts_pkg::FUNC_CREATE: begin
                        // claim the lowest free slot
                        if (!used_reg[walk_reg]) begin
                            we_prio                = 1'b1;
                            used_next[walk_reg]    = 1'b1;
                            delayed_next[walk_reg] = 1'b0;
                            count_next             = count_reg + 1'b1;
                            res_slot_next          = walk_reg;
                            state_next             = pts_pkg::S_DONE;
                        end else if (last_slot) begin
                            res_status_next = pts_pkg::ST_FULL;
                        end
                    end
                    pts_pkg::FUNC_TICK: begin
                        // wake when tick count reaches the wake tick
                        if (used_reg[walk_reg] && delayed_reg[walk_reg]
                                && (cmp_res.gt || cmp_res.eq)) begin
                            delayed_next[walk_reg] = 1'b0;
                        end
                    end
                    pts_pkg::FUNC_SCHED: begin
                        // highest priority ready task, lowest slot on ties
                        if (used_reg[walk_reg] && !delayed_reg[walk_reg]
                                && (!have_reg || cmp_res.gt)) begin
                            have_next      = 1'b1;
                            best_next      = walk_reg;
                            best_prio_next = rprio;
                        end
                        if (last_slot && have_next) begin
                            cur_next       = best_next;
                            res_slot_next  = best_next;
                            res_found_next = 1'b1;
                        end
                    end
                    default: begin
                        state_next = pts_pkg::S_DONE;
                    end
                endcase
            end

            pts_pkg::S_DONE: begin
                // load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_data_next.slot     = slot_wide[pts_pkg::SLOT_W-1:0];
                    m_data_next.found    = res_found_reg;
                    m_data_next.status   = res_status_reg;
                    m_data_next.tick_now = tick_reg;
                    state_next           = pts_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = pts_pkg::S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == pts_pkg::S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/pts_checker.sv
`include "priority_task_scheduler_macros.svh"

module pts_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input pts_pkg::out_t m_data
);

    // a stalled result beat holds
    `PTS_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // the block is busy right after taking an input beat
    `PTS_ASSERT(a_busy_after_in, s_valid && s_ready |=> !s_ready)

    // an error result names no slot and finds nothing
    `PTS_ASSERT(a_err_clean, m_valid && m_data.status != pts_pkg::ST_OK |-> !m_data.found && m_data.slot == '0)

    // reset drops the output valid
    `PTS_ASSERT_RST(a_rst_out, !aresetn |=> !m_valid)

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
